// File: rtl/toc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip package
// Shared widths, codes, reset values and structure types for the trip block.
// ----------------------------------------------------------------------------
package toc_pkg;

   localparam int TIER_COUNT = 3;
   localparam int TIER_SLOTS = 3;
   localparam int TIME_WIDTH = 48;

   localparam int NOW_W      = 48;
   localparam int CUR_W      = 16;
   localparam int THR_W      = 15;
   localparam int DWELL_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int TIER_IDX_W = 2;

   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIER0_THRESHOLD = 3'd0,
      CSR_TIER0_DWELL     = 3'd1,
      CSR_TIER1_THRESHOLD = 3'd2,
      CSR_TIER1_DWELL     = 3'd3,
      CSR_TIER2_THRESHOLD = 3'd4,
      CSR_TIER2_DWELL     = 3'd5,
      CSR_SAMPLE_INTERVAL = 3'd6
   } csr_index_type;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_RELAY  = 1'b1;

   localparam logic [THR_W-1:0]   TIER0_THR_RESET   = 15'd10000;
   localparam logic [DWELL_W-1:0] TIER0_DWELL_RESET = 24'd0;
   localparam logic [THR_W-1:0]   TIER1_THR_RESET   = 15'd6000;
   localparam logic [DWELL_W-1:0] TIER1_DWELL_RESET = 24'd200000;
   localparam logic [THR_W-1:0]   TIER2_THR_RESET   = 15'd4000;
   localparam logic [DWELL_W-1:0] TIER2_DWELL_RESET = 24'd2000000;
   localparam logic [DWELL_W-1:0] INTERVAL_RESET    = 24'd1000;

   typedef struct packed {
      logic [TIER_SLOTS-1:0][THR_W-1:0]   threshold;
      logic [TIER_SLOTS-1:0][DWELL_W-1:0] dwell;
      logic [DWELL_W-1:0]                 interval;
   } cfg_type;

   typedef struct packed {
      logic update;
      logic clear;
   } tier_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/toc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface toc_req_if import toc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic                    relay_value;
   logic [NOW_W-1:0]        now_us;
   logic signed [CUR_W-1:0] current_ma;

   modport source(output valid, mode, relay_value, now_us, current_ma, input ready);
   modport sink(input valid, mode, relay_value, now_us, current_ma, output ready);
endinterface

interface toc_rsp_if import toc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  enabled;
   logic                  tripped;
   logic                  trip_now;
   logic [TIER_IDX_W-1:0] trip_tier;
   logic                  write_refused;

   modport source(output valid, enabled, tripped, trip_now, trip_tier, write_refused,
                  input ready);
   modport sink(input valid, enabled, tripped, trip_now, trip_tier, write_refused,
                output ready);
endinterface

interface toc_csr_if import toc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/tiered_overcurrent_trip_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip
// Current samples and relay writes in, one status beat out per request beat.
// ----------------------------------------------------------------------------
// While not stalled, the block accepts one request beat per clock and
// returns one response beat for each: the beat enters an input register;
// when it moves on, all tiers are evaluated in parallel, the enable flag,
// trip latch, last sample time and tier timers are updated and the response
// register loaded. The state is updated with the response register, so the
// following beat always sees it. Output stalls hold the input register only
// while the response register is still full. Register writes take effect
// at once and are meant for idle periods; there is no startup clearing pass.
// ----------------------------------------------------------------------------
module tiered_overcurrent_trip_top import toc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   toc_req_if.sink   req_bus,
   toc_rsp_if.source rsp_bus,
   toc_csr_if.sink   csr_bus
);

   cfg_type cfg;

   // Input register.
   logic                    s1_valid_ff;
   logic                    s1_mode_ff;
   logic                    s1_relay_ff;
   time_type                s1_now_ff;
   logic signed [CUR_W-1:0] s1_cur_ff;

   // Block state.
   logic     enable_ff, enable_in;
   logic     latch_ff, latch_in;
   time_type last_ff, last_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_enabled_ff, rsp_tripped_ff, rsp_trip_now_ff, rsp_refused_ff;
   logic [TIER_IDX_W-1:0] rsp_tier_ff;

   logic                  advance, s1_go, req_go;
   logic                  sample_live, interval_ok, check, clear_timers;
   logic [TIER_COUNT-1:0] tier_trip, blocked;
   logic                  trip_any, refused;
   logic [TIER_IDX_W-1:0] trip_tier;
   tier_ctrl_type         tier_ctrl [TIER_COUNT];

   toc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go         = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_go        = req_bus.valid && req_bus.ready;

   assign sample_live  = (s1_mode_ff == MODE_SAMPLE) && !latch_ff;
   assign interval_ok  = time_type'(s1_now_ff - last_ff) >= TIME_WIDTH'(cfg.interval);
   assign check        = sample_live && enable_ff && interval_ok;
   assign clear_timers = sample_live && !enable_ff;

   for (genvar k = 0; k < TIER_COUNT; k++) begin : g_tier
      assign tier_ctrl[k].update = s1_go && check && !blocked[k];
      assign tier_ctrl[k].clear  = s1_go && clear_timers;

      toc_tier u_tier (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (tier_ctrl[k]),
         .now       (s1_now_ff),
         .current   (s1_cur_ff),
         .threshold (cfg.threshold[k]),
         .dwell     (cfg.dwell[k]),
         .trip      (tier_trip[k])
      );
   end

   // Lowest tripping tier wins; tiers above it keep their timers.
   always_comb begin
      blocked   = '0;
      trip_tier = '0;
      for (int k = 1; k < TIER_COUNT; k++) begin
         blocked[k] = blocked[k-1] || tier_trip[k-1];
      end
      for (int k = TIER_COUNT - 1; k >= 0; k--) begin
         if (tier_trip[k]) begin
            trip_tier = TIER_IDX_W'(k);
         end
      end
      if (!check) begin
         trip_tier = '0;
      end
   end

   assign trip_any = check && (|tier_trip);

   always_comb begin
      enable_in = enable_ff;
      latch_in  = latch_ff;
      last_in   = last_ff;
      refused   = 1'b0;
      if (s1_mode_ff == MODE_RELAY) begin
         if (!s1_relay_ff) begin
            enable_in = 1'b0;
            latch_in  = 1'b0;
         end else if (latch_ff) begin
            refused = 1'b1;
         end else begin
            enable_in = 1'b1;
         end
      end else if (check) begin
         last_in = s1_now_ff;
         if (trip_any) begin
            enable_in = 1'b0;
            latch_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         latch_ff     <= 1'b0;
         last_ff      <= '0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_go) begin
            enable_ff <= enable_in;
            latch_ff  <= latch_in;
            last_ff   <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_mode_ff  <= req_bus.mode;
         s1_relay_ff <= req_bus.relay_value;
         s1_now_ff   <= TIME_WIDTH'(req_bus.now_us);
         s1_cur_ff   <= req_bus.current_ma;
      end
      if (s1_go) begin
         rsp_enabled_ff  <= enable_in;
         rsp_tripped_ff  <= latch_in;
         rsp_trip_now_ff <= trip_any;
         rsp_tier_ff     <= trip_tier;
         rsp_refused_ff  <= refused;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.enabled       = rsp_enabled_ff;
   assign rsp_bus.tripped       = rsp_tripped_ff;
   assign rsp_bus.trip_now      = rsp_trip_now_ff;
   assign rsp_bus.trip_tier     = rsp_tier_ff;
   assign rsp_bus.write_refused = rsp_refused_ff;

   // The latch and the enable flag are never set together.
   a_latch_disables : assert property (@(posedge clock) disable iff (reset)
      !(latch_ff && enable_ff))
      else $error("trip latch set while enabled");

   // A fresh trip leaves the block latched and disabled.
   a_trip_state : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_trip_now_ff) |-> (rsp_tripped_ff && !rsp_enabled_ff))
      else $error("trip response without latched state");

   // The tier index only carries meaning together with a trip.
   a_tier_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_trip_now_ff) |-> (rsp_tier_ff == '0))
      else $error("trip tier set without a trip");

   // A refused write never coincides with a trip and never changes state.
   a_refused_quiet : assert property (@(posedge clock) disable iff (reset)
      (s1_go && refused) |=> ($stable(latch_ff) && $stable(enable_ff) && latch_ff))
      else $error("refused write changed state");

endmodule
`default_nettype wire

// File: rtl/toc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip register file
// Holds the tier thresholds, dwell times and the sample interval.
// ----------------------------------------------------------------------------
module toc_csr import toc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   toc_csr_if.sink    csr_bus,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_TIER0_THRESHOLD: cfg_in.threshold[0] = csr_bus.data[THR_W-1:0];
            CSR_TIER0_DWELL:     cfg_in.dwell[0]     = csr_bus.data[DWELL_W-1:0];
            CSR_TIER1_THRESHOLD: cfg_in.threshold[1] = csr_bus.data[THR_W-1:0];
            CSR_TIER1_DWELL:     cfg_in.dwell[1]     = csr_bus.data[DWELL_W-1:0];
            CSR_TIER2_THRESHOLD: cfg_in.threshold[2] = csr_bus.data[THR_W-1:0];
            CSR_TIER2_DWELL:     cfg_in.dwell[2]     = csr_bus.data[DWELL_W-1:0];
            CSR_SAMPLE_INTERVAL: cfg_in.interval     = csr_bus.data[DWELL_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold[0] <= TIER0_THR_RESET;
         cfg_ff.dwell[0]     <= TIER0_DWELL_RESET;
         cfg_ff.threshold[1] <= TIER1_THR_RESET;
         cfg_ff.dwell[1]     <= TIER1_DWELL_RESET;
         cfg_ff.threshold[2] <= TIER2_THR_RESET;
         cfg_ff.dwell[2]     <= TIER2_DWELL_RESET;
         cfg_ff.interval     <= INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/toc_tier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip tier timer
// One tier: threshold compare, dwell timer and trip decision.
// ----------------------------------------------------------------------------
module toc_tier import toc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tier_ctrl_type           ctrl,
   input  wire time_type                now,
   input  wire logic signed [CUR_W-1:0] current,
   input  wire logic [THR_W-1:0]        threshold,
   input  wire logic [DWELL_W-1:0]      dwell,
   output logic                         trip
);

   logic     running_ff, running_in;
   time_type start_ff, start_in;
   time_type start_eff;
   time_type elapsed;
   logic     at_threshold;

   assign at_threshold = current >= $signed({1'b0, threshold});

   // A timer that is not yet running starts with this very sample.
   assign start_eff = running_ff ? start_ff : now;
   assign elapsed   = now - start_eff;
   assign trip      = at_threshold && (elapsed >= TIME_WIDTH'(dwell));

   always_comb begin
      running_in = running_ff;
      start_in   = start_ff;
      if (ctrl.clear) begin
         running_in = 1'b0;
      end else if (ctrl.update) begin
         running_in = at_threshold;
         start_in   = start_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
      start_ff <= start_in;
   end

endmodule
`default_nettype wire

// File: verif/tb_tiered_overcurrent_trip_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tiered overcurrent trip testbench
// Drives current samples and relay writes into the trip block under random
// source gaps and sink stalls, keeps its own copy of the latch, enable flag,
// sample time and tier timers, and compares every status beat field by field.
// Several register settings are loaded between phases, the extremes among them.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic       enabled;
   logic       tripped;
   logic       trip_now;
   logic [1:0] trip_tier;
   logic       write_refused;
} trip_status_type;

class trip_status_tracker;
   logic [toc_pkg::THR_W-1:0]   threshold [toc_pkg::TIER_SLOTS];
   logic [toc_pkg::DWELL_W-1:0] dwell [toc_pkg::TIER_SLOTS];
   logic [toc_pkg::DWELL_W-1:0] interval;
   logic                        enabled;
   logic                        latched;
   toc_pkg::time_type           last_sample;
   toc_pkg::time_type           tier_start [toc_pkg::TIER_SLOTS];
   logic                        tier_running [toc_pkg::TIER_SLOTS];
   trip_status_type             pending_status [$];
   int unsigned                 mismatches;

   function new();
      threshold[0] = toc_pkg::TIER0_THR_RESET;
      threshold[1] = toc_pkg::TIER1_THR_RESET;
      threshold[2] = toc_pkg::TIER2_THR_RESET;
      dwell[0]     = toc_pkg::TIER0_DWELL_RESET;
      dwell[1]     = toc_pkg::TIER1_DWELL_RESET;
      dwell[2]     = toc_pkg::TIER2_DWELL_RESET;
      interval     = toc_pkg::INTERVAL_RESET;
      enabled      = 1'b0;
      latched      = 1'b0;
      last_sample  = '0;
      mismatches   = 0;
      for (int k = 0; k < toc_pkg::TIER_SLOTS; k++) begin
         tier_start[k]   = '0;
         tier_running[k] = 1'b0;
      end
   endfunction

   function void write_register(logic [toc_pkg::CSR_IDX_W-1:0] index,
                                logic [toc_pkg::CSR_DATA_W-1:0] data);
      case (index)
         toc_pkg::CSR_TIER0_THRESHOLD: threshold[0] = data[toc_pkg::THR_W-1:0];
         toc_pkg::CSR_TIER0_DWELL:     dwell[0]     = data;
         toc_pkg::CSR_TIER1_THRESHOLD: threshold[1] = data[toc_pkg::THR_W-1:0];
         toc_pkg::CSR_TIER1_DWELL:     dwell[1]     = data;
         toc_pkg::CSR_TIER2_THRESHOLD: threshold[2] = data[toc_pkg::THR_W-1:0];
         toc_pkg::CSR_TIER2_DWELL:     dwell[2]     = data;
         toc_pkg::CSR_SAMPLE_INTERVAL: interval     = data;
         default: ;
      endcase
   endfunction

   // Advances the tracked state by one accepted request beat and queues the
   // status beat it must produce.
   function void apply_request(logic mode, logic relay_value, toc_pkg::time_type now_us,
                               logic signed [toc_pkg::CUR_W-1:0] current_ma);
      trip_status_type   status;
      toc_pkg::time_type elapsed;
      int                level_ma;
      bit                hit;
      status   = '0;
      level_ma = int'(current_ma);
      hit      = 1'b0;
      if (mode == toc_pkg::MODE_RELAY) begin
         if (!relay_value) begin
            latched = 1'b0;
            enabled = 1'b0;
         end else if (latched) begin
            status.write_refused = 1'b1;
         end else begin
            enabled = 1'b1;
         end
      end else if (!latched) begin
         if (!enabled) begin
            for (int k = 0; k < toc_pkg::TIER_SLOTS; k++) begin
               tier_start[k]   = '0;
               tier_running[k] = 1'b0;
            end
         end else begin
            elapsed = now_us - last_sample;
            if (elapsed >= toc_pkg::TIME_WIDTH'(interval)) begin
               last_sample = now_us;
               // Once a tier trips, the tiers above it keep their timers.
               for (int k = 0; k < toc_pkg::TIER_COUNT; k++) begin
                  if (!hit) begin
                     if (level_ma >= int'(threshold[k])) begin
                        if (!tier_running[k]) begin
                           tier_running[k] = 1'b1;
                           tier_start[k]   = now_us;
                        end
                        elapsed = now_us - tier_start[k];
                        if (elapsed >= toc_pkg::TIME_WIDTH'(dwell[k])) begin
                           latched          = 1'b1;
                           enabled          = 1'b0;
                           status.trip_now  = 1'b1;
                           status.trip_tier = 2'(k);
                           hit              = 1'b1;
                        end
                     end else begin
                        tier_running[k] = 1'b0;
                        tier_start[k]   = '0;
                     end
                  end
               end
            end
         end
      end
      status.enabled = enabled;
      status.tripped = latched;
      pending_status.push_back(status);
   endfunction

   function int pending();
      return pending_status.size();
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_status(trip_status_type seen);
      trip_status_type want;
      if (pending_status.size() == 0) begin
         $error("status beat arrived with no request outstanding");
         mismatches++;
         return;
      end
      want = pending_status.pop_front();
      compare_field("enabled", 32'(want.enabled), 32'(seen.enabled));
      compare_field("tripped", 32'(want.tripped), 32'(seen.tripped));
      compare_field("trip_now", 32'(want.trip_now), 32'(seen.trip_now));
      compare_field("trip_tier", 32'(want.trip_tier), 32'(seen.trip_tier));
      compare_field("write_refused", 32'(want.write_refused), 32'(seen.write_refused));
   endfunction
endclass

module tb_tiered_overcurrent_trip_top;
   import toc_pkg::*;

   localparam int SETTLE_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 250;

   localparam logic [CSR_IDX_W-1:0]   CSR_UNUSED_INDEX = 3'd7;
   localparam time_type               TIME_MAX         = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [CUR_W-1:0] CUR_MIN         = 16'sh8000;
   localparam logic signed [CUR_W-1:0] CUR_MAX         = 16'sh7FFF;

   logic clock;
   logic reset;

   toc_req_if req_bus ();
   toc_rsp_if rsp_bus ();
   toc_csr_if csr_bus ();

   tiered_overcurrent_trip_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   trip_status_tracker tracker;
   bit                 hold_off_request;
   bit                 hold_off_active;
   int unsigned        gap_percent;
   int                 sustained_level;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Source side
   // -------------------------------------------------------------------------
   task automatic send_item(input logic mode, input logic relay_value,
                            input time_type now_us, input logic signed [CUR_W-1:0] current_ma);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.relay_value <= relay_value;
      req_bus.now_us      <= now_us;
      req_bus.current_ma  <= current_ma;
      do @(posedge clock); while (!req_bus.ready);
      tracker.apply_request(mode, relay_value, now_us, current_ma);
   endtask

   task automatic sender_gap();
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_percent)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and waits until every status beat owed has been received.
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_register(index, data);
   endtask

   task automatic load_phase_config(input int phase);
      logic [THR_W-1:0]      thr [TIER_SLOTS];
      logic [CSR_DATA_W-1:0] dwell_word [TIER_SLOTS];
      logic [CSR_DATA_W-1:0] interval_word;
      logic [CSR_DATA_W-1:0] upper_noise;
      upper_noise = CSR_DATA_W'($urandom);
      if (phase == 0) begin
         thr           = '{default: '0};
         dwell_word    = '{default: '0};
         interval_word = '0;
         upper_noise   = '0;
      end else if (phase == 1) begin
         thr           = '{default: '1};
         dwell_word    = '{default: '1};
         interval_word = '1;
         upper_noise   = '1;
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < TIER_SLOTS; k++) thr[k] = THR_W'($urandom_range(0, 32767));
         end else begin
            // Usual layout: the fast tier has the highest threshold.
            thr[0] = THR_W'($urandom_range(1000, 32767));
            thr[1] = THR_W'($urandom_range(0, 32'(thr[0])));
            thr[2] = THR_W'($urandom_range(0, 32'(thr[1])));
         end
         for (int k = 0; k < TIER_SLOTS; k++)
            dwell_word[k] = ($urandom_range(0, 3) == 0) ? '0
                                                        : CSR_DATA_W'($urandom_range(0, 20000));
         interval_word = ($urandom_range(0, 4) == 0) ? '0
                                                     : CSR_DATA_W'($urandom_range(1, 3000));
      end
      // Threshold writes carry noise above bit 14, which the block must drop.
      csr_write(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      csr_write(CSR_TIER0_THRESHOLD, {upper_noise[CSR_DATA_W-1:THR_W], thr[0]});
      csr_write(CSR_TIER0_DWELL, dwell_word[0]);
      csr_write(CSR_TIER1_THRESHOLD, {upper_noise[CSR_DATA_W-1:THR_W], thr[1]});
      csr_write(CSR_TIER1_DWELL, dwell_word[1]);
      csr_write(CSR_TIER2_THRESHOLD, {upper_noise[CSR_DATA_W-1:THR_W], thr[2]});
      csr_write(CSR_TIER2_DWELL, dwell_word[2]);
      csr_write(CSR_SAMPLE_INTERVAL, interval_word);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed traffic: enable after a trip, then samples spaced past
   // the sample interval with a current held near one tier's threshold.
   task automatic random_item();
      logic                     mode;
      logic                     relay_value;
      time_type                 now_us;
      logic signed [CUR_W-1:0]  current_ma;
      int unsigned              roll;
      int unsigned              span;
      int unsigned              k;
      mode        = MODE_SAMPLE;
      relay_value = 1'($urandom_range(0, 1));
      now_us      = time_type'({$urandom, $urandom});
      current_ma  = CUR_W'($urandom_range(0, 65535));
      roll        = $urandom_range(0, 99);
      if (tracker.latched) begin
         if (roll < 70) begin
            mode        = MODE_RELAY;
            relay_value = 1'b0;
         end else if (roll < 85) begin
            mode        = MODE_RELAY;
            relay_value = 1'b1;
         end
      end else if (!tracker.enabled) begin
         if (roll < 75) begin
            mode        = MODE_RELAY;
            relay_value = 1'b1;
         end else if (roll < 85) begin
            mode        = MODE_RELAY;
            relay_value = 1'b0;
         end
      end else if (roll < 6) begin
         mode = MODE_RELAY;
      end

      if (mode == MODE_SAMPLE) begin
         span = 64;
         for (int t = 0; t < TIER_SLOTS; t++)
            if (32'(tracker.dwell[t]) / 8 + 64 > span) span = 32'(tracker.dwell[t]) / 8 + 64;
         roll = $urandom_range(0, 99);
         if (roll >= 13)
            now_us = tracker.last_sample + time_type'(tracker.interval)
                     + time_type'($urandom_range(0, span));
         else if (roll >= 3)
            now_us = tracker.last_sample
                     + time_type'($urandom_range(0, 32'(tracker.interval)));

         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, TIER_SLOTS - 1);
            sustained_level = int'(tracker.threshold[k]) + int'($urandom_range(0, 6)) - 3;
         end
         roll = $urandom_range(0, 99);
         if (roll < 70)
            current_ma = CUR_W'(sustained_level + int'($urandom_range(0, 4)) - 2);
         else if (roll >= 90)
            case ($urandom_range(0, 3))
               0: current_ma = CUR_MIN;
               1: current_ma = CUR_MAX;
               2: current_ma = '0;
               default: current_ma = '1;
            endcase
      end
      send_item(mode, relay_value, now_us, current_ma);
      sender_gap();
   endtask

   initial begin
      tracker          = new();
      hold_off_request = 1'b0;
      hold_off_active  = 1'b0;
      gap_percent      = 20;
      sustained_level  = 0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= MODE_SAMPLE;
      req_bus.relay_value <= 1'b0;
      req_bus.now_us      <= '0;
      req_bus.current_ma  <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= '0;
      csr_bus.data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run with the register reset values.
      send_item(MODE_SAMPLE, 1'b1, 48'd5000, CUR_MAX);          // disabled: timers clear
      send_item(MODE_RELAY, 1'b1, 48'd0, CUR_MIN);              // enable
      send_item(MODE_RELAY, 1'b1, TIME_MAX, CUR_MAX);           // enable again
      send_item(MODE_SAMPLE, 1'b0, 48'd0, 16'sd4000);           // too early
      send_item(MODE_SAMPLE, 1'b1, 48'd1000, 16'sd4000);        // third tier starts
      send_item(MODE_SAMPLE, 1'b0, 48'd1500, 16'sd5000);        // too early
      send_item(MODE_SAMPLE, 1'b0, 48'd2000, CUR_MIN);          // negative never trips
      send_item(MODE_SAMPLE, 1'b0, 48'd3000, 16'sd10000);       // zero dwell trips tier 0
      send_item(MODE_SAMPLE, 1'b0, 48'd10000, '0);              // ignored while tripped
      send_item(MODE_RELAY, 1'b1, 48'd0, '0);                   // refused while latched
      send_item(MODE_RELAY, 1'b0, TIME_MAX, CUR_MAX);           // clear latch
      send_item(MODE_RELAY, 1'b1, 48'd0, CUR_MIN);
      send_item(MODE_SAMPLE, 1'b1, 48'd0, 16'sd6000);           // timers start at time zero
      send_item(MODE_SAMPLE, 1'b0, 48'd200000, 16'sd6000);      // tier 1 trips, tier 2 holds
      send_item(MODE_RELAY, 1'b0, 48'd0, '0);
      send_item(MODE_RELAY, 1'b1, 48'd0, '0);
      send_item(MODE_SAMPLE, 1'b0, TIME_MAX - 48'd999, 16'sd4000); // stale tier 2 timer
      send_item(MODE_RELAY, 1'b0, 48'd0, '0);
      send_item(MODE_RELAY, 1'b1, 48'd0, '0);
      send_item(MODE_SAMPLE, 1'b0, TIME_MAX, CUR_MAX);          // too early across the wrap
      send_item(MODE_SAMPLE, 1'b1, 48'd999, CUR_MAX);           // accepted across the wrap
      send_item(MODE_RELAY, 1'b0, 48'd0, '0);
      send_item(MODE_RELAY, 1'b1, 48'd0, '0);
      send_item(MODE_RELAY, 1'b0, 48'd0, '0);                   // disable while running
      drain_requests();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_phase_config(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 60 == 0)
               case ($urandom_range(0, 2))
                  0: gap_percent = 0;
                  1: gap_percent = 10;
                  default: gap_percent = 40;
               endcase
            if (phase == 2 && n == 100) begin
               // Keep offering beats through a long sink hold-off.
               req_bus.valid <= 1'b0;
               hold_off_request = 1'b1;
               @(posedge clock);
               wait (hold_off_active);
               gap_percent = 0;
            end
            if (phase == 4 && n == 120) drain_requests();
            random_item();
         end
         drain_requests();
      end

      if (tracker.pending() != 0) begin
         $error("%0d status beats never arrived", tracker.pending());
         tracker.mismatches++;
      end
      if (tracker.mismatches == 0)
         $display("tiered_overcurrent_trip_top test passed");
      else
         $display("tiered_overcurrent_trip_top test failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sink side
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_active  = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_off_active  = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
               @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : status_monitor
      trip_status_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.enabled       = rsp_bus.enabled;
         seen.tripped       = rsp_bus.tripped;
         seen.trip_now      = rsp_bus.trip_now;
         seen.trip_tier     = rsp_bus.trip_tier;
         seen.write_refused = rsp_bus.write_refused;
         tracker.check_status(seen);
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tiered_overcurrent_trip_top test failed");
      $finish;
   end

endmodule
`default_nettype wire

// File: tiered_overcurrent_trip_top.f
rtl/toc_pkg.sv
rtl/toc_if.sv
rtl/toc_csr.sv
rtl/toc_tier.sv
rtl/tiered_overcurrent_trip_top.sv
verif/tb_tiered_overcurrent_trip_top.sv
